>>> hdl/srnw_pkg.sv
// Shared types, constants and codes for the sensor registry block.
// No dependencies; every other file imports this package.
package srnw_pkg;

   localparam int TABLE_DEPTH = 8;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int DIV_W = 6;

   localparam logic [15:0] MAGIC_RESET  = 16'd48878;
   localparam logic [31:0] PERIOD_RESET = 32'd120000;

   typedef enum logic [1:0] {
      CMD_ADVERT = 2'd0,
      CMD_WINDOW = 2'd1,
      CMD_COUNT  = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_UPDATED    = 3'd0,
      ST_REGISTERED = 3'd1,
      ST_FULL       = 3'd2,
      ST_REJECTED   = 3'd3,
      ST_BAD_INDEX  = 3'd4,
      ST_OK         = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      UNIT_1000HZ = 2'd0,
      UNIT_64HZ   = 2'd1,
      UNIT_1HZ    = 2'd2,
      UNIT_100HZ  = 2'd3
   } unit_type;

   typedef enum logic {
      CSR_MAGIC  = 1'b0,
      CSR_PERIOD = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DISPATCH,
      FSM_ADV_EVAL,
      FSM_ADV_WRITE,
      FSM_SCAN,
      FSM_DIV,
      FSM_ROLL,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] now_ms;
      logic [47:0] sensor_address;
      logic        name_ok;
      logic [15:0] magic;
      logic [3:0]  metric_type;
      logic [1:0]  timer_unit;
      logic [31:0] next_transmission;
      logic [31:0] payload;
      logic [3:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] window_time;
      logic [15:0] advert_tally;
      logic [3:0]  sensor_count;
      logic [47:0] entry_address;
      logic [3:0]  entry_type;
      logic [31:0] entry_payload;
      logic [63:0] entry_last_receive;
      logic [63:0] entry_next_announce;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic adv_eval;
      logic adv_write;
      logic scan_step;
      logic div_start;
      logic div_step;
      logic roll_done;
      logic rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      cmd_type command;
      logic    scan_end;
      logic    need_div;
      logic    div_last;
   } ctl_sts_type;

endpackage

>>> hdl/srnw_ctrl.sv
// Controller state machine for the sensor registry.
// Depends on srnw_pkg; drives command strobes to srnw_datapath.
module srnw_ctrl import srnw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);

   fsm_type state_ff, state_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state; DISPATCH routes on the command held in the item register
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) state_in = FSM_DISPATCH;
         end
         FSM_DISPATCH: begin
            unique case (sts.command)
               CMD_ADVERT:          state_in = FSM_ADV_EVAL;
               CMD_WINDOW:          state_in = FSM_SCAN;
               CMD_COUNT, CMD_READ: state_in = FSM_DONE;
            endcase
         end
         FSM_ADV_EVAL:  state_in = FSM_ADV_WRITE;
         FSM_ADV_WRITE: state_in = FSM_DONE;
         FSM_SCAN: begin
            priority if (sts.scan_end) state_in = FSM_DONE;
            else if (sts.need_div)     state_in = FSM_DIV;
         end
         FSM_DIV: begin
            if (sts.div_last) state_in = FSM_ROLL;
         end
         FSM_ROLL: state_in = FSM_SCAN;
         FSM_DONE: begin
            if (out_free) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // command strobes
   always_comb begin
      cmd              = '0;
      cmd.load_req     = (state_ff == FSM_IDLE) && req_valid;
      cmd.adv_eval     = (state_ff == FSM_ADV_EVAL);
      cmd.adv_write    = (state_ff == FSM_ADV_WRITE);
      cmd.scan_step    = (state_ff == FSM_SCAN) && !sts.scan_end && !sts.need_div;
      cmd.div_start    = (state_ff == FSM_SCAN) && !sts.scan_end && sts.need_div;
      cmd.div_step     = (state_ff == FSM_DIV);
      cmd.roll_done    = (state_ff == FSM_ROLL);
      cmd.rsp_load     = (state_ff == FSM_DONE) && out_free;
      rsp_valid_in     = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   ap_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("result not presented after load");
   ap_roll_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_ROLL) |=> (state_ff == FSM_SCAN))
      else $error("roll step did not return to scan");
   ap_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> !req_ready)
      else $error("accepted a word while busy");

endmodule

>>> hdl/srnw_datapath.sv
// Datapath: item register, sensor table, interval scaler, roll divider, output register.
// Depends on srnw_pkg; sequenced by srnw_ctrl.
module srnw_datapath import srnw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  ctl_cmd_type cmd,
   output ctl_sts_type sts,
   output rsp_type     rsp_data
);

   logic [15:0] magic_ff;
   logic [31:0] period_ff;
   req_type     req_ff;

   logic [47:0] addr_ff    [TABLE_DEPTH];
   logic [3:0]  type_ff    [TABLE_DEPTH];
   logic [31:0] pay_ff     [TABLE_DEPTH];
   logic [63:0] rx_ff      [TABLE_DEPTH];
   logic [63:0] ann_ff     [TABLE_DEPTH];
   logic [CNT_W-1:0] total_ff;
   logic [15:0] counter_ff;

   logic [31:0]      interval_ff;
   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic             adv_ok_ff;
   status_type       status_ff;

   logic [CNT_W-1:0] idx_ff;
   logic [63:0]      win_ff;
   logic [63:0]      cand_ff;
   logic             cand_valid_ff;
   logic [63:0]      dvd_ff;
   logic [31:0]      rem_ff;
   logic [DIV_W-1:0] div_cnt_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic [IDX_W-1:0] rd_idx;
   logic [63:0]      rd_ann;
   logic             scan_live;
   logic [31:0]      period_eff;
   logic [32:0]      rem_shift;
   logic [32:0]      rem_sub;
   logic [34:0]      t125;
   logic [31:0]      interval;
   logic             hit;
   logic [IDX_W-1:0] hit_idx;
   logic [31:0]      roll_add;
   logic [64:0]      roll_sum;
   logic [63:0]      rolled;
   logic [63:0]      next_ann;
   logic             read_ok;

   assign rd_idx     = (cmd_type'(req_ff.command) == CMD_READ) ?
                       IDX_W'(req_ff.entry_index) : idx_ff[IDX_W-1:0];
   assign rd_ann     = ann_ff[rd_idx];
   assign scan_live  = (idx_ff < total_ff);
   assign period_eff = (period_ff == 32'd0) ? 32'd1 : period_ff;
   assign rem_shift  = {rem_ff, dvd_ff[63]};
   assign rem_sub    = rem_shift - {1'b0, period_eff};
   assign t125       = {3'b000, req_ff.next_transmission} * 35'd125;
   assign read_ok    = ({28'd0, req_ff.entry_index} < TABLE_DEPTH);

   always_comb begin
      unique case (unit_type'(req_ff.timer_unit))
         UNIT_1000HZ: interval = req_ff.next_transmission;
         UNIT_64HZ:   interval = t125[34:3];  // 15625/1000 == 125/8
         UNIT_1HZ:    interval = req_ff.next_transmission * 32'd1000;
         UNIT_100HZ:  interval = req_ff.next_transmission * 32'd10;
      endcase
   end

   // parallel address match over live entries, lowest slot wins
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (CNT_W'(i) < total_ff && addr_ff[i] == req_ff.sensor_address) begin
            hit     = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign next_ann = req_ff.now_ms + {32'd0, interval_ff};
   assign roll_add = period_eff - rem_ff;
   assign roll_sum = {1'b0, req_ff.now_ms} + {33'd0, roll_add};
   assign rolled   = (rem_ff == 32'd0) ? req_ff.now_ms :
                     roll_sum[64] ? {64{1'b1}} : roll_sum[63:0];

   assign sts.command  = cmd_type'(req_ff.command);
   assign sts.scan_end = !scan_live && !cand_valid_ff;
   assign sts.need_div = scan_live && rd_ann != 64'd0 && rd_ann < req_ff.now_ms;
   assign sts.div_last = (div_cnt_ff == '1);
   assign rsp_data     = rsp_ff;

   // result word assembled from the current item and table
   always_comb begin
      rsp_in              = '0;
      rsp_in.advert_tally = counter_ff;
      rsp_in.sensor_count = 4'(total_ff);
      unique case (cmd_type'(req_ff.command))
         CMD_ADVERT: rsp_in.status = status_ff;
         CMD_WINDOW: begin
            rsp_in.status      = ST_OK;
            rsp_in.window_time = win_ff;
         end
         CMD_COUNT: rsp_in.status = ST_OK;
         CMD_READ: begin
            if (read_ok) begin
               rsp_in.status              = ST_OK;
               rsp_in.entry_address       = addr_ff[rd_idx];
               rsp_in.entry_type          = type_ff[rd_idx];
               rsp_in.entry_payload       = pay_ff[rd_idx];
               rsp_in.entry_last_receive  = rx_ff[rd_idx];
               rsp_in.entry_next_announce = ann_ff[rd_idx];
            end else begin
               rsp_in.status = ST_BAD_INDEX;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= MAGIC_RESET;
         period_ff  <= PERIOD_RESET;
         total_ff   <= '0;
         counter_ff <= '0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            addr_ff[i] <= '0;
            type_ff[i] <= '0;
            pay_ff[i]  <= '0;
            rx_ff[i]   <= '0;
            ann_ff[i]  <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_type'(csr_index))
               CSR_MAGIC:  magic_ff  <= csr_wdata[15:0];
               CSR_PERIOD: period_ff <= csr_wdata;
            endcase
         end
         if (cmd.adv_write && adv_ok_ff) begin
            counter_ff <= counter_ff + 16'd1;
            if (hit_ff || total_ff < TABLE_DEPTH) begin
               addr_ff[hit_ff ? hit_idx_ff : total_ff[IDX_W-1:0]] <= req_ff.sensor_address;
               type_ff[hit_ff ? hit_idx_ff : total_ff[IDX_W-1:0]] <= req_ff.metric_type;
               pay_ff [hit_ff ? hit_idx_ff : total_ff[IDX_W-1:0]] <= req_ff.payload;
               rx_ff  [hit_ff ? hit_idx_ff : total_ff[IDX_W-1:0]] <= req_ff.now_ms;
               ann_ff [hit_ff ? hit_idx_ff : total_ff[IDX_W-1:0]] <= next_ann;
            end
            if (!hit_ff && total_ff < TABLE_DEPTH) total_ff <= total_ff + CNT_W'(1);
         end
         if (cmd.rsp_load && cmd_type'(req_ff.command) == CMD_COUNT) counter_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff        <= req_data;
         idx_ff        <= '0;
         win_ff        <= '0;
         cand_valid_ff <= 1'b0;
      end else begin
         cand_valid_ff <= (cmd.scan_step && scan_live && rd_ann != 64'd0) || cmd.roll_done;
         if (cand_valid_ff && (win_ff == 64'd0 || win_ff > cand_ff)) win_ff <= cand_ff;
         if (cmd.scan_step && scan_live) begin
            idx_ff <= idx_ff + CNT_W'(1);
            if (rd_ann != 64'd0) cand_ff <= rd_ann;
         end
         if (cmd.roll_done) begin
            idx_ff  <= idx_ff + CNT_W'(1);
            cand_ff <= rolled;
         end
      end
      if (cmd.adv_eval) begin
         interval_ff <= interval;
         hit_ff      <= hit;
         hit_idx_ff  <= hit_idx;
         adv_ok_ff   <= req_ff.name_ok && (req_ff.magic == magic_ff);
      end
      if (cmd.adv_write) begin
         priority if (!adv_ok_ff)          status_ff <= ST_REJECTED;
         else if (hit_ff)                  status_ff <= ST_UPDATED;
         else if (total_ff < TABLE_DEPTH)  status_ff <= ST_REGISTERED;
         else                              status_ff <= ST_FULL;
      end
      // restoring remainder, one dividend bit per cycle
      if (cmd.div_start) begin
         dvd_ff     <= req_ff.now_ms - rd_ann;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff     <= {dvd_ff[62:0], 1'b0};
         div_cnt_ff <= div_cnt_ff + DIV_W'(1);
         if (rem_shift >= {1'b0, period_eff}) rem_ff <= rem_sub[31:0];
         else                                 rem_ff <= rem_shift[31:0];
      end
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

endmodule

>>> hdl/sensor_registry_next_window.sv
// Sensor registry with next-window prediction: top level.
// Sequence, accept to result valid: advert dispatches, evaluates, writes; count/read
//   dispatch only; window query scans each entry, and a stale entry adds a remainder
//   over all 64 dividend bits and a roll step, plus a merge when the last entry yields a time.
// One word in processing; input is ready again in the cycle after the result loads;
//   a result not yet taken holds the next word in its final state until taken.
// Synchronous active-high reset clears the table and counts, reloads magic and period, idles the FSM.
module sensor_registry_next_window import srnw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // sequencer: dispatch, entry scan, remainder iterations, result handoff
   srnw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table, interval scaling, roll-forward remainder and window minimum
   srnw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
